FILE: rtl/cir_pkg.sv
// ----------------------------------------------------------------------------
// cir_pkg
// Shared types, constants and arithmetic helpers of the contact resolver.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package cir_pkg;

  localparam int COMP_W   = 16;
  localparam int NUM_COMP = 3;
  localparam int VEC_W    = 48;
  localparam int MASS_W   = 16;
  localparam int TIM_W    = MASS_W + 1;
  localparam int REST_W   = 9;
  localparam int E_ONE    = 256;

  // square root unit: 48-bit radicand, one root bit per stage
  localparam int SQ_W     = 48;
  localparam int SQ_STEPS = SQ_W / 2;
  localparam int ROOT_W   = SQ_W / 2;
  localparam int SQ_SHIFT = 14;

  // divider unit: one quotient bit per stage
  localparam int DIV_NW   = 48;
  localparam int DIV_DW   = 24;
  localparam int DIV_QW   = 28;

  localparam int NRM_SHIFT = 23;
  localparam int DV_SHIFT  = 16;
  localparam int RND_SHIFT = 24;
  localparam int PEN_SHIFT = 8;
  localparam int NM_W      = 18;
  localparam int DV_W      = 28;
  localparam int PROD_W    = DV_W + NM_W;

  typedef enum logic [1:0] {
    KIND_BOTH = 2'd0,
    KIND_VEL  = 2'd1,
    KIND_PEN  = 2'd2,
    KIND_NONE = 2'd3
  } kind_e;

  typedef struct packed {
    logic [1:0]        kind;
    logic [VEC_W-1:0]  pos_a;
    logic [VEC_W-1:0]  pos_b;
    logic [VEC_W-1:0]  vel_a;
    logic [VEC_W-1:0]  vel_b;
    logic [MASS_W-1:0] inv_mass_a;
    logic [MASS_W-1:0] inv_mass_b;
    logic [15:0]       penetration;
  } cir_in_t;

  typedef struct packed {
    logic [VEC_W-1:0] new_vel_a;
    logic [VEC_W-1:0] new_vel_b;
    logic [VEC_W-1:0] shift_a;
    logic [VEC_W-1:0] shift_b;
    logic             velocity_changed;
    logic             position_changed;
    logic             saturated;
  } cir_out_t;

  typedef logic [NUM_COMP-1:0][COMP_W-1:0] vec_t;
  typedef logic [NUM_COMP-1:0][COMP_W:0]   dvec_t;
  typedef logic [NUM_COMP-1:0][NM_W-1:0]   nvec_t;

  // per-contact context carried alongside the front end, sqrt and normal divide
  typedef struct packed {
    kind_e             kind;
    logic              nop;
    vec_t              va;
    vec_t              vb;
    dvec_t             d;
    dvec_t             dvel;
    logic [MASS_W-1:0] ima;
    logic [MASS_W-1:0] imb;
    logic [15:0]       pen;
    logic [TIM_W-1:0]  tim;
  } fr_t;

  // context carried across the mass divide
  typedef struct packed {
    logic                do_vel;
    logic                do_pos;
    logic                vchg;
    vec_t                va;
    vec_t                vb;
    nvec_t               nm;
    logic [NUM_COMP-1:0] ns;
  } mv_t;

  // round half away from zero of a magnitude by 2^24
  function automatic logic [PROD_W-RND_SHIFT:0] rnd24(logic [PROD_W-1:0] p);
    logic [PROD_W:0] t;
    t = {1'b0, p} + (PROD_W+1)'(1 << (RND_SHIFT - 1));
    return t[PROD_W:RND_SHIFT];
  endfunction

  // clamp to the signed component range, flag in the top bit
  function automatic logic [COMP_W:0] sat_comp(logic signed [23:0] v);
    logic signed [23:0] smax;
    logic signed [23:0] smin;
    smax = 24'sd32767;
    smin = -24'sd32768;
    if (v > smax) begin
      return {1'b1, 1'b0, {(COMP_W-1){1'b1}}};
    end else if (v < smin) begin
      return {1'b1, 1'b1, {(COMP_W-1){1'b0}}};
    end
    return {1'b0, v[COMP_W-1:0]};
  endfunction

endpackage

FILE: rtl/cir_sqrt.sv
// ----------------------------------------------------------------------------
// cir_sqrt
// Pipelined integer square root, one root bit resolved per stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cir_sqrt import cir_pkg::*; (
  input  logic              clk_i,
  input  logic              en_i,
  input  logic [SQ_W-1:0]   x_i,
  output logic [ROOT_W-1:0] root_o
);

  logic [SQ_STEPS-1:0][SQ_W-1:0] x_q, x_d, r_q, r_d;

  always_comb begin
    logic [SQ_W-1:0] xin;
    logic [SQ_W-1:0] rin;
    logic [SQ_W-1:0] bv;
    logic [SQ_W:0]   trial;
    for (int k = 0; k < SQ_STEPS; k++) begin
      xin = (k == 0) ? x_i : x_q[(k == 0) ? 0 : k-1];
      rin = (k == 0) ? '0 : r_q[(k == 0) ? 0 : k-1];
      bv  = SQ_W'(1) << (SQ_W - 2 - 2*k);
      trial = {1'b0, rin} + {1'b0, bv};
      if ({1'b0, xin} >= trial) begin
        x_d[k] = xin - trial[SQ_W-1:0];
        r_d[k] = (rin >> 1) + bv;
      end else begin
        x_d[k] = xin;
        r_d[k] = rin >> 1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q <= x_d;
      r_q <= r_d;
    end
  end

  assign root_o = r_q[SQ_STEPS-1][ROOT_W-1:0];

endmodule

FILE: rtl/cir_div.sv
// ----------------------------------------------------------------------------
// cir_div
// Pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cir_div import cir_pkg::*; (
  input  logic              clk_i,
  input  logic              en_i,
  input  logic [DIV_NW-1:0] num_i,
  input  logic [DIV_DW-1:0] den_i,
  output logic [DIV_QW-1:0] quo_o
);

  logic [DIV_QW-1:0][DIV_DW-1:0] rem_q, rem_d, den_q, den_d;
  logic [DIV_QW-1:0][DIV_QW-1:0] lo_q, lo_d;

  always_comb begin
    logic [DIV_DW-1:0] rin;
    logic [DIV_DW-1:0] din;
    logic [DIV_QW-1:0] lin;
    logic [DIV_DW:0]   t;
    logic              qb;
    for (int k = 0; k < DIV_QW; k++) begin
      // the high part starts below the divisor since the quotient fits
      rin = (k == 0) ? DIV_DW'(num_i[DIV_NW-1:DIV_QW]) : rem_q[(k == 0) ? 0 : k-1];
      din = (k == 0) ? den_i : den_q[(k == 0) ? 0 : k-1];
      lin = (k == 0) ? num_i[DIV_QW-1:0] : lo_q[(k == 0) ? 0 : k-1];
      t   = {rin, lin[DIV_QW-1]};
      qb  = (t >= {1'b0, din});
      if (qb) begin
        t = t - {1'b0, din};
      end
      rem_d[k] = t[DIV_DW-1:0];
      den_d[k] = din;
      lo_d[k]  = {lin[DIV_QW-2:0], qb};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q <= rem_d;
      den_q <= den_d;
      lo_q  <= lo_d;
    end
  end

  assign quo_o = lo_q[DIV_QW-1];

endmodule

FILE: rtl/contact_impulse_resolver_core.sv
// throughput: one contact per cycle while not stalled; the sqrt (24 stages)
// and the normal and mass divider banks (28 stages each) are fully
// pipelined, one bit per stage
// a full output register with out_ready_i low stalls the whole pipeline
// reset clears all valid bits and sets restitution to 1.0; no clearing pass
// ----------------------------------------------------------------------------
// contact_impulse_resolver_core
// Impulse based contact resolution with restitution, pipelined top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module contact_impulse_resolver_core import cir_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  cir_in_t           in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output cir_out_t          out_data_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [REST_W-1:0] cfg_data_i
);

  logic              en;
  logic [REST_W-1:0] rest_q;

  assign en          = !out_valid_o || out_ready_i;
  assign in_ready_o  = en;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rest_q <= REST_W'(E_ONE);
    end else if (cfg_valid_i) begin
      rest_q <= cfg_data_i;
    end
  end

  // valid bits of every stage
  logic                s1_v_q, s2_v_q, s3_v_q;
  logic [SQ_STEPS-1:0] sa_v_q;
  logic [DIV_QW-1:0]   sb_v_q;
  logic                s4_v_q, s5_v_q, s6_v_q, s7_v_q;
  logic [DIV_QW-1:0]   sc_v_q;
  logic                s8_v_q, out_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      s3_v_q  <= 1'b0;
      sa_v_q  <= '0;
      sb_v_q  <= '0;
      s4_v_q  <= 1'b0;
      s5_v_q  <= 1'b0;
      s6_v_q  <= 1'b0;
      s7_v_q  <= 1'b0;
      sc_v_q  <= '0;
      s8_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else if (en) begin
      s1_v_q  <= in_valid_i;
      s2_v_q  <= s1_v_q;
      s3_v_q  <= s2_v_q;
      sa_v_q  <= {sa_v_q[SQ_STEPS-2:0], s3_v_q};
      sb_v_q  <= {sb_v_q[DIV_QW-2:0], sa_v_q[SQ_STEPS-1]};
      s4_v_q  <= sb_v_q[DIV_QW-1];
      s5_v_q  <= s4_v_q;
      s6_v_q  <= s5_v_q;
      s7_v_q  <= s6_v_q;
      sc_v_q  <= {sc_v_q[DIV_QW-2:0], s7_v_q};
      s8_v_q  <= sc_v_q[DIV_QW-1];
      out_v_q <= s8_v_q;
    end
  end

  assign out_valid_o = out_v_q;

  // ---- stage 1: unpack, differences
  fr_t s1_d, s1_q;

  always_comb begin
    s1_d.kind = kind_e'(in_data_i.kind);
    s1_d.ima  = in_data_i.inv_mass_a;
    s1_d.imb  = in_data_i.inv_mass_b;
    s1_d.pen  = in_data_i.penetration;
    s1_d.tim  = TIM_W'(in_data_i.inv_mass_a) + TIM_W'(in_data_i.inv_mass_b);
    for (int i = 0; i < NUM_COMP; i++) begin
      s1_d.va[i]   = in_data_i.vel_a[i*COMP_W +: COMP_W];
      s1_d.vb[i]   = in_data_i.vel_b[i*COMP_W +: COMP_W];
      s1_d.d[i]    = (COMP_W+1)'($signed(in_data_i.pos_a[i*COMP_W +: COMP_W]))
                   - (COMP_W+1)'($signed(in_data_i.pos_b[i*COMP_W +: COMP_W]));
      s1_d.dvel[i] = (COMP_W+1)'($signed(in_data_i.vel_a[i*COMP_W +: COMP_W]))
                   - (COMP_W+1)'($signed(in_data_i.vel_b[i*COMP_W +: COMP_W]));
    end
    s1_d.nop = (s1_d.kind == KIND_NONE) || (s1_d.tim == '0);
  end

  // ---- stage 2: squares of the position difference
  fr_t                               s2_q;
  logic [NUM_COMP-1:0][2*COMP_W-1:0] sq_d, sq_q;

  always_comb begin
    logic [COMP_W-1:0] m;
    for (int i = 0; i < NUM_COMP; i++) begin
      m = s1_q.d[i][COMP_W] ? COMP_W'(-s1_q.d[i]) : s1_q.d[i][COMP_W-1:0];
      sq_d[i] = m * m;
    end
  end

  // ---- stage 3: squared length
  fr_t                 s3_d, s3_q;
  logic [2*COMP_W+1:0] s2len_d, s2len_q;

  always_comb begin
    s2len_d = (2*COMP_W+2)'(sq_q[0]) + (2*COMP_W+2)'(sq_q[1]) + (2*COMP_W+2)'(sq_q[2]);
    s3_d     = s2_q;
    s3_d.nop = s2_q.nop || (s2len_d == '0);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_q    <= s1_d;
      s2_q    <= s1_q;
      sq_q    <= sq_d;
      s3_q    <= s3_d;
      s2len_q <= s2len_d;
    end
  end

  // ---- length of the difference vector
  logic [ROOT_W-1:0] len;

  cir_sqrt u_sqrt (
    .clk_i  (clk_i),
    .en_i   (en),
    .x_i    ({s2len_q, SQ_SHIFT'(0)}),
    .root_o (len)
  );

  fr_t sa_q [SQ_STEPS];
  fr_t sb_q [DIV_QW];

  always_ff @(posedge clk_i) begin
    if (en) begin
      sa_q[0] <= s3_q;
      for (int k = 1; k < SQ_STEPS; k++) begin
        sa_q[k] <= sa_q[k-1];
      end
      sb_q[0] <= sa_q[SQ_STEPS-1];
      for (int k = 1; k < DIV_QW; k++) begin
        sb_q[k] <= sb_q[k-1];
      end
    end
  end

  // ---- unit normal, one divider per component
  logic [NUM_COMP-1:0][DIV_NW-1:0] nnum;
  logic [NUM_COMP-1:0][DIV_QW-1:0] nquo;

  always_comb begin
    logic [COMP_W-1:0] m;
    for (int i = 0; i < NUM_COMP; i++) begin
      m = sa_q[SQ_STEPS-1].d[i][COMP_W] ? COMP_W'(-sa_q[SQ_STEPS-1].d[i])
                                        : sa_q[SQ_STEPS-1].d[i][COMP_W-1:0];
      nnum[i] = ({DIV_NW'(m)} << NRM_SHIFT) + DIV_NW'(len >> 1);
    end
  end

  for (genvar i = 0; i < NUM_COMP; i++) begin : g_ndiv
    cir_div u_ndiv (
      .clk_i (clk_i),
      .en_i  (en),
      .num_i (nnum[i]),
      .den_i (len),
      .quo_o (nquo[i])
    );
  end

  // ---- stage 4: separating speed products
  fr_t                                   s4_q;
  nvec_t                                 nm_d, nm4_q, nm5_q, nm6_q;
  logic [NUM_COMP-1:0]                   ns_d, ns4_q, ns5_q, ns6_q;
  logic signed [NUM_COMP-1:0][35:0]      sp_d, sp_q;

  always_comb begin
    logic signed [NM_W:0] nsg;
    for (int i = 0; i < NUM_COMP; i++) begin
      nm_d[i] = nquo[i][NM_W-1:0];
      ns_d[i] = sb_q[DIV_QW-1].d[i][COMP_W];
      nsg     = ns_d[i] ? -$signed({1'b0, nm_d[i]}) : $signed({1'b0, nm_d[i]});
      sp_d[i] = 36'($signed(sb_q[DIV_QW-1].dvel[i])) * 36'(nsg);
    end
  end

  // ---- stage 5: sum
  fr_t                s5_q;
  logic signed [37:0] sep_d, sep_q;

  assign sep_d = 38'($signed(sp_q[0])) + 38'($signed(sp_q[1])) + 38'($signed(sp_q[2]));

  // ---- stage 6: velocity change with restitution
  fr_t              s6_q;
  logic [DV_W-1:0]  dv_d, dv_q;
  logic             app_d, app_q;

  always_comb begin
    logic [36:0]         m;
    logic [REST_W:0]     f;
    logic [46:0]         pr;
    m  = 37'(-sep_q);
    f  = (REST_W+1)'(E_ONE) + ((rest_q > REST_W'(E_ONE)) ? (REST_W+1)'(E_ONE)
                                                          : (REST_W+1)'(rest_q));
    pr = (47'(m) * 47'(f)) + 47'(1 << (DV_SHIFT - 1));
    dv_d  = pr[DV_SHIFT +: DV_W];
    app_d = !s5_q.nop && sep_q[37]
            && ((s5_q.kind == KIND_BOTH) || (s5_q.kind == KIND_VEL));
  end

  // ---- stage 7: mass split numerators
  mv_t                             s7_d, s7_q;
  logic [3:0][DIV_NW-1:0]          mnum_d, mnum_q;
  logic [DIV_DW-1:0]               tim7_q;

  always_comb begin
    logic [DIV_NW-1:0] half;
    logic [DIV_NW-1:0] pen8;
    half = DIV_NW'(s6_q.tim >> 1);
    pen8 = DIV_NW'(s6_q.pen) << PEN_SHIFT;
    mnum_d[0] = DIV_NW'(dv_q) * DIV_NW'(s6_q.ima) + half;
    mnum_d[1] = DIV_NW'(dv_q) * DIV_NW'(s6_q.imb) + half;
    mnum_d[2] = pen8 * DIV_NW'(s6_q.ima) + half;
    mnum_d[3] = pen8 * DIV_NW'(s6_q.imb) + half;
    s7_d.do_vel = app_q;
    s7_d.do_pos = !s6_q.nop && ((s6_q.kind == KIND_BOTH) || (s6_q.kind == KIND_PEN));
    s7_d.vchg   = app_q && (dv_q != '0);
    s7_d.va     = s6_q.va;
    s7_d.vb     = s6_q.vb;
    s7_d.nm     = nm6_q;
    s7_d.ns     = ns6_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s4_q   <= sb_q[DIV_QW-1];
      nm4_q  <= nm_d;
      ns4_q  <= ns_d;
      sp_q   <= sp_d;
      s5_q   <= s4_q;
      nm5_q  <= nm4_q;
      ns5_q  <= ns4_q;
      sep_q  <= sep_d;
      s6_q   <= s5_q;
      nm6_q  <= nm5_q;
      ns6_q  <= ns5_q;
      dv_q   <= dv_d;
      app_q  <= app_d;
      s7_q   <= s7_d;
      mnum_q <= mnum_d;
      tim7_q <= DIV_DW'(s6_q.tim);
    end
  end

  // ---- impulse and penetration shares
  logic [3:0][DIV_QW-1:0] mquo;

  for (genvar j = 0; j < 4; j++) begin : g_mdiv
    cir_div u_mdiv (
      .clk_i (clk_i),
      .en_i  (en),
      .num_i (mnum_q[j]),
      .den_i (tim7_q),
      .quo_o (mquo[j])
    );
  end

  mv_t sc_q [DIV_QW];

  always_ff @(posedge clk_i) begin
    if (en) begin
      sc_q[0] <= s7_q;
      for (int k = 1; k < DIV_QW; k++) begin
        sc_q[k] <= sc_q[k-1];
      end
    end
  end

  // ---- stage 8: share times normal
  mv_t                                    s8_q;
  logic [3:0][NUM_COMP-1:0][PROD_W-1:0]   pp_d, pp_q;

  always_comb begin
    for (int j = 0; j < 4; j++) begin
      for (int i = 0; i < NUM_COMP; i++) begin
        pp_d[j][i] = PROD_W'(mquo[j]) * PROD_W'(sc_q[DIV_QW-1].nm[i]);
      end
    end
  end

  // ---- output stage: round, apply, saturate
  cir_out_t out_d, out_q;

  always_comb begin
    logic signed [23:0] e0, e1, e2, e3;
    logic [COMP_W:0]    r0, r1, r2, r3;
    logic               vs, ps, pc;
    vs = 1'b0;
    ps = 1'b0;
    pc = 1'b0;
    out_d = '0;
    for (int i = 0; i < NUM_COMP; i++) begin
      e0 = 24'(rnd24(pp_q[0][i]));
      e1 = 24'(rnd24(pp_q[1][i]));
      e2 = 24'(rnd24(pp_q[2][i]));
      e3 = 24'(rnd24(pp_q[3][i]));
      if (s8_q.ns[i]) begin
        e0 = -e0;
        e1 = -e1;
        e2 = -e2;
        e3 = -e3;
      end
      r0 = sat_comp(24'($signed(s8_q.va[i])) + e0);
      r1 = sat_comp(24'($signed(s8_q.vb[i])) - e1);
      r2 = sat_comp(e2);
      r3 = sat_comp(-e3);
      vs = vs | r0[COMP_W] | r1[COMP_W];
      ps = ps | r2[COMP_W] | r3[COMP_W];
      pc = pc | (r2[COMP_W-1:0] != '0) | (r3[COMP_W-1:0] != '0);
      out_d.new_vel_a[i*COMP_W +: COMP_W] = s8_q.do_vel ? r0[COMP_W-1:0] : s8_q.va[i];
      out_d.new_vel_b[i*COMP_W +: COMP_W] = s8_q.do_vel ? r1[COMP_W-1:0] : s8_q.vb[i];
      out_d.shift_a[i*COMP_W +: COMP_W]   = s8_q.do_pos ? r2[COMP_W-1:0] : '0;
      out_d.shift_b[i*COMP_W +: COMP_W]   = s8_q.do_pos ? r3[COMP_W-1:0] : '0;
    end
    out_d.velocity_changed = s8_q.vchg;
    out_d.position_changed = s8_q.do_pos && pc;
    out_d.saturated        = (s8_q.do_vel && vs) || (s8_q.do_pos && ps);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s8_q  <= sc_q[DIV_QW-1];
      pp_q  <= pp_d;
      out_q <= out_d;
    end
  end

  assign out_data_o = out_q;

endmodule

FILE: tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the contact resolver: random and directed contacts,
// restitution changes between phases, in-bench model of the fixed-point math.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import cir_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  cir_in_t in_data_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  cir_out_t out_data_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [REST_W-1:0] cfg_data_i = '0;

  contact_impulse_resolver_core u_dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_ready_o(in_ready_o), .in_data_i(in_data_i),
    .out_valid_o(out_valid_o), .out_ready_i(out_ready_i), .out_data_o(out_data_o),
    .cfg_valid_i(cfg_valid_i), .cfg_ready_o(cfg_ready_o), .cfg_data_i(cfg_data_i)
  );

  localparam int LATENCY = 89;
  localparam int WATCHDOG = 20000;

  cir_in_t contact_q[$];
  cir_out_t resolved_q[$];
  logic [REST_W-1:0] rest_coef = REST_W'(E_ONE);
  logic in_fire = 1'b0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int errors = 0;
  int n_sent = 0;
  int n_checked = 0;
  int n_vchg = 0;
  int n_pchg = 0;
  int n_sat = 0;
  int quiet_cycles = 0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic longint comp_of(logic [VEC_W-1:0] w, int i);
    return longint'($signed(w[i*COMP_W +: COMP_W]));
  endfunction

  function automatic longint mag_of(longint x);
    return x < 0 ? -x : x;
  endfunction

  function automatic longint shr_rnd(longint x, int k);
    longint m;
    m = (mag_of(x) + (longint'(1) << (k - 1))) >>> k;
    return x < 0 ? -m : m;
  endfunction

  function automatic longint div_rnd(longint num, longint den);
    longint m;
    m = (mag_of(num) + den / 2) / den;
    return num < 0 ? -m : m;
  endfunction

  function automatic longint int_sqrt(longint x);
    longint r;
    longint b;
    r = 0;
    b = longint'(1) << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic longint clamp_comp(longint v, ref logic flag);
    if (v > 32767) begin
      flag = 1'b1;
      return 32767;
    end
    if (v < -32768) begin
      flag = 1'b1;
      return -32768;
    end
    return v;
  endfunction

  function automatic cir_out_t resolve_contact(cir_in_t c, logic [REST_W-1:0] coef);
    cir_out_t r;
    longint d[3], va[3], vb[3], nrm[3], sa[3], sb[3];
    longint s2, len, sep, dv, dva, dvb, pa, pb, tim, e;
    logic satf;
    logic pchg;
    logic vchg;
    s2 = 0;
    satf = 1'b0;
    pchg = 1'b0;
    vchg = 1'b0;
    tim = longint'(c.inv_mass_a) + longint'(c.inv_mass_b);
    for (int i = 0; i < 3; i++) begin
      d[i] = comp_of(c.pos_a, i) - comp_of(c.pos_b, i);
      va[i] = comp_of(c.vel_a, i);
      vb[i] = comp_of(c.vel_b, i);
      sa[i] = 0;
      sb[i] = 0;
      s2 += d[i] * d[i];
    end
    if (kind_e'(c.kind) != KIND_NONE && tim != 0 && s2 != 0) begin
      len = int_sqrt(s2 << 14);
      for (int i = 0; i < 3; i++) nrm[i] = div_rnd(d[i] * (longint'(1) << 23), len);
      if (kind_e'(c.kind) == KIND_BOTH || kind_e'(c.kind) == KIND_VEL) begin
        sep = 0;
        for (int i = 0; i < 3; i++) sep += (va[i] - vb[i]) * nrm[i];
        if (sep < 0) begin
          e = coef > E_ONE ? E_ONE : longint'(coef);
          dv = shr_rnd(-sep * (E_ONE + e), 16);
          dva = div_rnd(dv * longint'(c.inv_mass_a), tim);
          dvb = div_rnd(dv * longint'(c.inv_mass_b), tim);
          vchg = dv != 0;
          for (int i = 0; i < 3; i++) begin
            va[i] = clamp_comp(va[i] + shr_rnd(dva * nrm[i], 24), satf);
            vb[i] = clamp_comp(vb[i] - shr_rnd(dvb * nrm[i], 24), satf);
          end
        end
      end
      if (kind_e'(c.kind) == KIND_BOTH || kind_e'(c.kind) == KIND_PEN) begin
        pa = div_rnd((longint'(c.penetration) << 8) * longint'(c.inv_mass_a), tim);
        pb = div_rnd((longint'(c.penetration) << 8) * longint'(c.inv_mass_b), tim);
        for (int i = 0; i < 3; i++) begin
          sa[i] = clamp_comp(shr_rnd(pa * nrm[i], 24), satf);
          sb[i] = clamp_comp(-shr_rnd(pb * nrm[i], 24), satf);
          if (sa[i] != 0 || sb[i] != 0) pchg = 1'b1;
        end
      end
    end
    for (int i = 0; i < 3; i++) begin
      r.new_vel_a[i*COMP_W +: COMP_W] = va[i][COMP_W-1:0];
      r.new_vel_b[i*COMP_W +: COMP_W] = vb[i][COMP_W-1:0];
      r.shift_a[i*COMP_W +: COMP_W] = sa[i][COMP_W-1:0];
      r.shift_b[i*COMP_W +: COMP_W] = sb[i][COMP_W-1:0];
    end
    r.velocity_changed = vchg;
    r.position_changed = pchg;
    r.saturated = satf;
    return r;
  endfunction

  function automatic logic [VEC_W-1:0] rand_vec(int span);
    logic [VEC_W-1:0] w;
    for (int i = 0; i < 3; i++) begin
      if (span == 0) w[i*COMP_W +: COMP_W] = COMP_W'($urandom);
      else w[i*COMP_W +: COMP_W] = COMP_W'($urandom_range(2 * span) - span);
    end
    return w;
  endfunction

  // mostly realistic contacts, some full-range noise
  function automatic cir_in_t rand_contact();
    cir_in_t c;
    int span;
    int pick;
    pick = $urandom_range(99);
    span = pick < 30 ? 0 : (pick < 60 ? 4096 : 512);
    c.kind = pick < 90 ? 2'($urandom_range(2)) : 2'($urandom);
    c.pos_a = rand_vec(span);
    c.pos_b = $urandom_range(19) == 0 ? c.pos_a : rand_vec(span);
    c.vel_a = rand_vec(span);
    c.vel_b = rand_vec(span);
    c.inv_mass_a = $urandom_range(9) == 0 ? 16'd0 : 16'($urandom);
    c.inv_mass_b = $urandom_range(9) == 0 ? 16'd0 : 16'($urandom);
    c.penetration = 16'($urandom);
    return c;
  endfunction

  function automatic cir_in_t mk_contact(kind_e k, logic [VEC_W-1:0] pa,
                                         logic [VEC_W-1:0] pb, logic [VEC_W-1:0] va,
                                         logic [VEC_W-1:0] vb, logic [15:0] ma,
                                         logic [15:0] mb, logic [15:0] pen);
    cir_in_t c;
    c.kind = k;
    c.pos_a = pa;
    c.pos_b = pb;
    c.vel_a = va;
    c.vel_b = vb;
    c.inv_mass_a = ma;
    c.inv_mass_b = mb;
    c.penetration = pen;
    return c;
  endfunction

  function automatic void add_contact(cir_in_t c);
    contact_q.insert(contact_q.size(), c);
  endfunction

  // driver
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!in_valid_i || in_fire) begin
        if (contact_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_data_i <= contact_q.pop_front();
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
      out_ready_i <= $urandom_range(99) >= recv_stall_pct;
    end
  end

  // monitor and scoreboard
  always @(posedge clk_i) begin
    cir_out_t exp_r;
    in_fire <= in_valid_i && in_ready_o;
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (in_valid_i && in_ready_o) begin
        resolved_q.insert(resolved_q.size(), resolve_contact(in_data_i, rest_coef));
        n_sent <= n_sent + 1;
      end
      if (out_valid_o && out_ready_i) begin
        if (resolved_q.size() == 0) begin
          $error("unexpected result word %h", out_data_o);
          errors <= errors + 1;
        end else begin
          exp_r = resolved_q.pop_front();
          n_checked <= n_checked + 1;
          n_vchg <= n_vchg + exp_r.velocity_changed;
          n_pchg <= n_pchg + exp_r.position_changed;
          n_sat <= n_sat + exp_r.saturated;
          if (out_data_o.new_vel_a !== exp_r.new_vel_a)
            $error("new_vel_a exp %h got %h", exp_r.new_vel_a, out_data_o.new_vel_a);
          if (out_data_o.new_vel_b !== exp_r.new_vel_b)
            $error("new_vel_b exp %h got %h", exp_r.new_vel_b, out_data_o.new_vel_b);
          if (out_data_o.shift_a !== exp_r.shift_a)
            $error("shift_a exp %h got %h", exp_r.shift_a, out_data_o.shift_a);
          if (out_data_o.shift_b !== exp_r.shift_b)
            $error("shift_b exp %h got %h", exp_r.shift_b, out_data_o.shift_b);
          if (out_data_o.velocity_changed !== exp_r.velocity_changed)
            $error("velocity_changed exp %b got %b", exp_r.velocity_changed,
                   out_data_o.velocity_changed);
          if (out_data_o.position_changed !== exp_r.position_changed)
            $error("position_changed exp %b got %b", exp_r.position_changed,
                   out_data_o.position_changed);
          if (out_data_o.saturated !== exp_r.saturated)
            $error("saturated exp %b got %b", exp_r.saturated, out_data_o.saturated);
          if (out_data_o !== exp_r) errors <= errors + 1;
        end
      end
      if (quiet_cycles > WATCHDOG) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  task automatic drain();
    while (contact_q.size() > 0 || in_valid_i || resolved_q.size() > 0) @(posedge clk_i);
  endtask

  task automatic write_restitution(logic [REST_W-1:0] v);
    @(negedge clk_i);
    cfg_data_i <= v;
    cfg_valid_i <= 1'b1;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    rest_coef = v;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  localparam logic [VEC_W-1:0] ONE_X = 48'h0000_0000_0100;
  localparam logic [VEC_W-1:0] MAX_V = 48'h7FFF_7FFF_7FFF;
  localparam logic [VEC_W-1:0] MIN_V = 48'h8000_8000_8000;

  initial begin
    logic [REST_W-1:0] rest_set[5];
    rest_set = '{9'd256, 9'd0, 9'd511, 9'd128, 9'd300};
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed contacts at reset restitution
    add_contact(mk_contact(KIND_BOTH, ONE_X, '0, '0, ONE_X, 16'h1000, 16'h1000, 16'h0100));
    add_contact(mk_contact(KIND_VEL, ONE_X, '0, '0, ONE_X, 16'h1000, 16'h0000, 16'h0100));
    add_contact(mk_contact(KIND_PEN, ONE_X, '0, '0, ONE_X, 16'h0000, 16'h1000, 16'hFFFF));
    add_contact(mk_contact(KIND_NONE, ONE_X, '0, '0, ONE_X, 16'h1000, 16'h1000, 16'h0100));
    add_contact(mk_contact(KIND_BOTH, ONE_X, '0, '0, ONE_X, 16'h0000, 16'h0000, 16'h0100));
    add_contact(mk_contact(KIND_BOTH, ONE_X, ONE_X, '0, ONE_X, 16'h1000, 16'h1000, 16'h0100));
    add_contact(mk_contact(KIND_BOTH, ONE_X, '0, ONE_X, '0, 16'h1000, 16'h1000, 16'h0100));
    add_contact(mk_contact(KIND_BOTH, ONE_X, '0, '0, '0, 16'h1000, 16'h1000, 16'h0000));
    add_contact(mk_contact(KIND_BOTH, MAX_V, MIN_V, MIN_V, MAX_V, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    add_contact(mk_contact(KIND_BOTH, MIN_V, MAX_V, MAX_V, MIN_V, 16'hFFFF, 16'h0001, 16'hFFFF));
    add_contact(mk_contact(KIND_VEL, MAX_V, MIN_V, MIN_V, MAX_V, 16'h0001, 16'hFFFF, 16'h0000));
    add_contact(mk_contact(KIND_PEN, 48'hFFFF_FFFF_FFFF, '0, '0, '0, 16'h8000, 16'h0001,
                           16'hFFFF));
    add_contact(mk_contact(KIND_BOTH, 48'h0001_0000_0000, '0, 48'h8000_0000_0000,
                           MAX_V, 16'h0FFF, 16'hF000, 16'h8000));
    drain();

    // random phases: each restitution setting with one idling pattern
    for (int ph = 0; ph < 5; ph++) begin
      if (ph > 0) begin
        repeat (LATENCY + 10) @(posedge clk_i);
        write_restitution(rest_set[ph]);
      end
      case (ph)
        1: begin send_idle_pct = 66; recv_stall_pct = 0; end
        2: begin send_idle_pct = 0; recv_stall_pct = 66; end
        3: begin send_idle_pct = 12; recv_stall_pct = 12; end
        default: begin send_idle_pct = 0; recv_stall_pct = 0; end
      endcase
      for (int k = 0; k < 200; k++) add_contact(rand_contact());
      drain();
    end

    repeat (LATENCY + 10) @(posedge clk_i);
    $display("checked %0d of %0d contacts: %0d impulses, %0d shifts, %0d clamped",
             n_checked, n_sent, n_vchg, n_pchg, n_sat);
    $display("five restitution settings (0, 1.0, 0.5, above 1.0) under mixed stalls");
    if (errors == 0 && resolved_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
